[design/lzos_pkg.sv]
// shared types and constants for the lidar zone obstacle steering block
// register indexes, reset values, stage and result structs
// no dependencies
`default_nettype none

package lzos_pkg;

   // coordinate widths
   localparam int MM_W    = 16;   // raw lidar coordinate
   localparam int CM_W    = 14;   // scaled coordinate, magnitude up to 3276
   localparam int ROW_W   = 13;   // crop row position
   localparam int CMP_W   = 16;   // signed width for zone compares
   localparam int SPEED_W = 8;
   localparam int GAIN_W  = 4;
   localparam int REG_W   = 8;
   localparam int IDX_W   = 3;

   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 24;

   // 52429 / 2^19 is close enough to 1/10 to give an exact quotient for 16-bit magnitudes
   localparam logic [MM_W-1:0] RECIP_TEN = 16'd52429;
   localparam int RECIP_SHIFT = 19;

   localparam logic [SPEED_W-1:0] SPEED_SLOW   = 8'd4;
   localparam logic [SPEED_W-1:0] SPEED_CRUISE = 8'd8;
   localparam logic [SPEED_W-1:0] SPEED_STOP   = 8'd0;

   typedef enum logic [IDX_W-1:0] {
      REG_HALF_WIDTH   = 3'd0,
      REG_BUMPER_WIDTH = 3'd1,
      REG_ZONE_HEIGHT  = 3'd2,
      REG_SAFETY_GAP   = 3'd3,
      REG_BUMPER_LIMIT = 3'd4,
      REG_SAFETY_LIMIT = 3'd5,
      REG_SPEED_GAIN   = 3'd6
   } reg_index_type;

   localparam logic [REG_W-1:0]  RST_HALF_WIDTH   = 8'd20;
   localparam logic [REG_W-1:0]  RST_BUMPER_WIDTH = 8'd20;
   localparam logic [REG_W-1:0]  RST_ZONE_HEIGHT  = 8'd40;
   localparam logic [REG_W-1:0]  RST_SAFETY_GAP   = 8'd5;
   localparam logic [REG_W-1:0]  RST_BUMPER_LIMIT = 8'd1;
   localparam logic [REG_W-1:0]  RST_SAFETY_LIMIT = 8'd1;
   localparam logic [GAIN_W-1:0] RST_SPEED_GAIN   = 4'd2;

   typedef enum logic {
      KIND_POINT = 1'b0,
      KIND_ROW   = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic [REG_W-1:0]  robot_half_width;
      logic [REG_W-1:0]  bumper_width;
      logic [REG_W-1:0]  zone_height;
      logic [REG_W-1:0]  safety_gap;
      logic [REG_W-1:0]  bumper_hit_limit;
      logic [REG_W-1:0]  safety_hit_limit;
      logic [GAIN_W-1:0] speed_gain;
   } cfg_type;

   // request as captured at the input register
   typedef struct packed {
      req_kind_type             kind;
      logic                     last_point;
      logic signed [MM_W-1:0]   sample_x;
      logic signed [MM_W-1:0]   sample_y;
      logic signed [ROW_W-1:0]  row_a_pos;
      logic signed [ROW_W-1:0]  row_b_pos;
   } raw_req_type;

   // request after scaling to centimeters
   typedef struct packed {
      req_kind_type             kind;
      logic                     last_point;
      logic signed [CM_W-1:0]   x_cm;
      logic signed [CM_W-1:0]   y_cm;
      logic signed [ROW_W-1:0]  row_a_pos;
      logic signed [ROW_W-1:0]  row_b_pos;
   } scaled_req_type;

   typedef struct packed {
      logic [SPEED_W-1:0] speed_left;
      logic [SPEED_W-1:0] speed_right;
      logic               left_bump;
      logic               right_bump;
      logic               safety_stop;
      logic               left_hard;
      logic               right_hard;
   } rsp_type;

endpackage

`default_nettype wire

[design/lidar_zone_obstacle_steering.sv]
// lidar zone obstacle steering, top level: config registers, input register, response register
// path: a request lands in the input register and its response is then registered in the
// response register; scaling and zone logic settle between the two registers
// throughput: one request per cycle; both registers advance together, held only by a full
// response register that is not being taken; a point that is not last gives no response
// reset: synchronous active high, clears counters, flags and valids, loads register defaults
`default_nettype none

module lidar_zone_obstacle_steering
   import lzos_pkg::*;
#(
   parameter int HIT_COUNT_BITS = 8
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [15:0] sample_x, [31:16] sample_y, [44:32] row_a_pos, [57:45] row_b_pos, rest zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [0] req_type
   input  wire logic                  req_tuser,
   // last_point
   input  wire logic                  req_tlast,
   // response stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [7:0] speed_left, [15:8] speed_right, [16] left_bump, [17] right_bump,
   // [18] safety_stop, [19] left_hard, [20] right_hard, [23:21] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // configuration writes
   input  wire logic                  csr_we,
   input  wire logic [IDX_W-1:0]      csr_index,
   input  wire logic [REG_W-1:0]      csr_wdata
);

   cfg_type                cfg_ff;
   raw_req_type            raw_ff, raw_in;
   logic                   raw_valid_ff;
   scaled_req_type         scl_req;
   logic signed [CM_W-1:0] x_cm, y_cm;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff;
   logic                   advance;
   logic                   has_result;

   // both registers move when the response register is free or being drained
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   // configuration registers, index past the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.robot_half_width <= RST_HALF_WIDTH;
         cfg_ff.bumper_width     <= RST_BUMPER_WIDTH;
         cfg_ff.zone_height      <= RST_ZONE_HEIGHT;
         cfg_ff.safety_gap       <= RST_SAFETY_GAP;
         cfg_ff.bumper_hit_limit <= RST_BUMPER_LIMIT;
         cfg_ff.safety_hit_limit <= RST_SAFETY_LIMIT;
         cfg_ff.speed_gain       <= RST_SPEED_GAIN;
      end else if (csr_we) begin
         case (csr_index)
            REG_HALF_WIDTH:   cfg_ff.robot_half_width <= csr_wdata;
            REG_BUMPER_WIDTH: cfg_ff.bumper_width     <= csr_wdata;
            REG_ZONE_HEIGHT:  cfg_ff.zone_height      <= csr_wdata;
            REG_SAFETY_GAP:   cfg_ff.safety_gap       <= csr_wdata;
            REG_BUMPER_LIMIT: cfg_ff.bumper_hit_limit <= csr_wdata;
            REG_SAFETY_LIMIT: cfg_ff.safety_hit_limit <= csr_wdata;
            REG_SPEED_GAIN:   cfg_ff.speed_gain       <= csr_wdata[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // unpack the request into the input register
   always_comb begin
      raw_in.kind       = req_kind_type'(req_tuser);
      raw_in.last_point = req_tlast;
      raw_in.sample_x   = signed'(req_tdata[15:0]);
      raw_in.sample_y   = signed'(req_tdata[31:16]);
      raw_in.row_a_pos  = signed'(req_tdata[44:32]);
      raw_in.row_b_pos  = signed'(req_tdata[57:45]);
   end

   // millimeters to centimeters, y axis flipped
   lzos_scale u_scale_x (
      .mm     (raw_ff.sample_x),
      .negate (1'b0),
      .cm     (x_cm)
   );

   lzos_scale u_scale_y (
      .mm     (raw_ff.sample_y),
      .negate (1'b1),
      .cm     (y_cm)
   );

   always_comb begin
      scl_req.kind       = raw_ff.kind;
      scl_req.last_point = raw_ff.last_point;
      scl_req.x_cm       = x_cm;
      scl_req.y_cm       = y_cm;
      scl_req.row_a_pos  = raw_ff.row_a_pos;
      scl_req.row_b_pos  = raw_ff.row_b_pos;
   end

   // zone counting, flags and wheel speeds, in the same cycle as the scaling
   lzos_zone #(
      .HIT_COUNT_BITS (HIT_COUNT_BITS)
   ) u_zone (
      .clock      (clock),
      .reset      (reset),
      .update     (advance && raw_valid_ff),
      .cfg        (cfg_ff),
      .item       (scl_req),
      .has_result (has_result),
      .result     (rsp_in)
   );

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         raw_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         raw_valid_ff <= req_tvalid;
         rsp_valid_ff <= raw_valid_ff && has_result;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         raw_ff <= raw_in;
         if (raw_valid_ff && has_result) begin
            rsp_ff <= rsp_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000,
                        rsp_ff.right_hard,
                        rsp_ff.left_hard,
                        rsp_ff.safety_stop,
                        rsp_ff.right_bump,
                        rsp_ff.left_bump,
                        rsp_ff.speed_right,
                        rsp_ff.speed_left};

endmodule

`default_nettype wire

[design/lzos_scale.sv]
// divide-by-ten of one signed millimeter coordinate, truncated toward zero
// optional negation of the quotient; uses lzos_pkg
`default_nettype none

module lzos_scale
   import lzos_pkg::*;
(
   input  wire logic signed [MM_W-1:0] mm,
   input  wire logic                   negate,
   output logic signed [CM_W-1:0]      cm
);

   logic [MM_W-1:0]      mag;
   logic [2*MM_W-1:0]    prod;
   logic [CM_W-2:0]      quo;
   logic                 flip;

   // magnitude of -32768 is 32768, still fits unsigned
   assign mag  = mm[MM_W-1] ? MM_W'(-mm) : MM_W'(mm);
   assign prod = (2*MM_W)'(mag) * (2*MM_W)'(RECIP_TEN);
   assign quo  = prod[RECIP_SHIFT +: CM_W-1];
   assign flip = mm[MM_W-1] ^ negate;
   assign cm   = flip ? -signed'({1'b0, quo}) : signed'({1'b0, quo});

endmodule

`default_nettype wire

[design/lzos_zone.sv]
// zone hit counters, zone and hard flags, wheel speed priority
// holds the scan state; uses lzos_pkg
`default_nettype none

module lzos_zone
   import lzos_pkg::*;
#(
   parameter int HIT_COUNT_BITS = 8
)(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           update,
   input  wire cfg_type        cfg,
   input  wire scaled_req_type item,
   output logic                has_result,
   output rsp_type             result
);

   localparam int LIM_W = (HIT_COUNT_BITS > REG_W) ? HIT_COUNT_BITS : REG_W;

   logic [HIT_COUNT_BITS-1:0] left_hits_ff, right_hits_ff, safety_hits_ff;
   logic [HIT_COUNT_BITS-1:0] left_hits_in, right_hits_in, safety_hits_in;
   logic [HIT_COUNT_BITS-1:0] left_inc, right_inc, safety_inc;
   logic left_flag_ff, right_flag_ff, safety_flag_ff, left_hard_ff, right_hard_ff;
   logic left_flag_in, right_flag_in, safety_flag_in, left_hard_in, right_hard_in;

   logic signed [CMP_W-1:0] hw, bw, zh, gap;
   logic signed [CMP_W-1:0] px, py, ra, rb;
   logic signed [CMP_W-1:0] left_lo, left_hi, right_hi, safe_y_lo, safe_y_hi;
   logic in_bumper_y, hit_left, hit_right, hit_safety;
   logic row_left, row_right;
   logic [SPEED_W-1:0] gain8, gain12;

   assign hw  = signed'(CMP_W'(cfg.robot_half_width));
   assign bw  = signed'(CMP_W'(cfg.bumper_width));
   assign zh  = signed'(CMP_W'(cfg.zone_height));
   assign gap = signed'(CMP_W'(cfg.safety_gap));

   assign px = CMP_W'(item.x_cm);
   assign py = CMP_W'(item.y_cm);
   assign ra = CMP_W'(item.row_a_pos);
   assign rb = CMP_W'(item.row_b_pos);

   // zone edges, all inclusive
   assign left_lo   = -bw - hw;
   assign left_hi   = -hw;
   assign right_hi  = hw + bw;
   assign safe_y_lo = -zh - gap;
   assign safe_y_hi = -gap;

   assign in_bumper_y = (py >= -zh) && (py <= 0);
   assign hit_left    = in_bumper_y && (px >= left_lo) && (px <= left_hi);
   assign hit_right   = in_bumper_y && (px >= hw) && (px <= right_hi);
   assign hit_safety  = (px >= -hw) && (px <= hw) && (py >= safe_y_lo) && (py <= safe_y_hi);

   // row sits at the bumper front edge, always within bumper height
   assign row_left  = ((ra >= left_lo) && (ra <= left_hi)) ||
                      ((rb >= left_lo) && (rb <= left_hi));
   assign row_right = ((ra >= hw) && (ra <= right_hi)) ||
                      ((rb >= hw) && (rb <= right_hi));

   // saturating increments
   assign left_inc   = (hit_left && (left_hits_ff != '1)) ?
                       left_hits_ff + HIT_COUNT_BITS'(1) : left_hits_ff;
   assign right_inc  = (hit_right && (right_hits_ff != '1)) ?
                       right_hits_ff + HIT_COUNT_BITS'(1) : right_hits_ff;
   assign safety_inc = (hit_safety && (safety_hits_ff != '1)) ?
                       safety_hits_ff + HIT_COUNT_BITS'(1) : safety_hits_ff;

   always_comb begin
      left_hits_in   = left_hits_ff;
      right_hits_in  = right_hits_ff;
      safety_hits_in = safety_hits_ff;
      left_flag_in   = left_flag_ff;
      right_flag_in  = right_flag_ff;
      safety_flag_in = safety_flag_ff;
      left_hard_in   = left_hard_ff;
      right_hard_in  = right_hard_ff;
      has_result     = 1'b0;
      case (item.kind)
         KIND_POINT: begin
            if (item.last_point) begin
               left_flag_in   = LIM_W'(left_inc) >= LIM_W'(cfg.bumper_hit_limit);
               right_flag_in  = LIM_W'(right_inc) >= LIM_W'(cfg.bumper_hit_limit);
               safety_flag_in = LIM_W'(safety_inc) >= LIM_W'(cfg.safety_hit_limit);
               left_hits_in   = '0;
               right_hits_in  = '0;
               safety_hits_in = '0;
               has_result     = 1'b1;
            end else begin
               left_hits_in   = left_inc;
               right_hits_in  = right_inc;
               safety_hits_in = safety_inc;
            end
         end
         KIND_ROW: begin
            left_flag_in  = left_flag_ff | row_left;
            right_flag_in = right_flag_ff | row_right;
            right_hard_in = (ra < hw) && (ra > -hw);
            left_hard_in  = (rb < hw) && (rb > -hw);
            has_result    = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign gain8  = SPEED_W'({cfg.speed_gain, 3'b000});
   assign gain12 = SPEED_W'({cfg.speed_gain, 3'b000}) + SPEED_W'({cfg.speed_gain, 2'b00});

   always_comb begin
      result.left_bump   = left_flag_in;
      result.right_bump  = right_flag_in;
      result.safety_stop = safety_flag_in;
      result.left_hard   = left_hard_in;
      result.right_hard  = right_hard_in;
      if (safety_flag_in) begin
         result.speed_left  = SPEED_STOP;
         result.speed_right = SPEED_STOP;
      end else if (right_hard_in) begin
         result.speed_left  = SPEED_SLOW;
         result.speed_right = gain12;
      end else if (left_hard_in) begin
         result.speed_left  = gain12;
         result.speed_right = SPEED_SLOW;
      end else if (right_flag_in) begin
         result.speed_left  = SPEED_SLOW;
         result.speed_right = gain8;
      end else if (left_flag_in) begin
         result.speed_left  = gain8;
         result.speed_right = SPEED_SLOW;
      end else begin
         result.speed_left  = SPEED_CRUISE;
         result.speed_right = SPEED_CRUISE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_hits_ff   <= '0;
         right_hits_ff  <= '0;
         safety_hits_ff <= '0;
         left_flag_ff   <= 1'b0;
         right_flag_ff  <= 1'b0;
         safety_flag_ff <= 1'b0;
         left_hard_ff   <= 1'b0;
         right_hard_ff  <= 1'b0;
      end else if (update) begin
         left_hits_ff   <= left_hits_in;
         right_hits_ff  <= right_hits_in;
         safety_hits_ff <= safety_hits_in;
         left_flag_ff   <= left_flag_in;
         right_flag_ff  <= right_flag_in;
         safety_flag_ff <= safety_flag_in;
         left_hard_ff   <= left_hard_in;
         right_hard_ff  <= right_hard_in;
      end
   end

endmodule

`default_nettype wire
